// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and constants for the bitmap first-fit allocator
// Field widths, command codes, sequencer states and memory control.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Field widths of the channels
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int RUN_W   = 11;
  localparam int LEN_W   = 11;
  localparam int START_W = 10;

  // Bits scanned per cycle: one memory word
  localparam int WORD_LW = 4;
  localparam int WORD_W  = 1 << WORD_LW;

  // Reset value of the covered length register
  localparam logic [LEN_W-1:0] LEN_RST = 11'd1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Memory port control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

// File: rtl/core/bfa_if.sv
// ----------------------------------------------------------------------------
// bfa_if: channel interfaces of the bitmap first-fit allocator
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------

// Request channel: one command per request
interface bfa_req_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] bit_index;
  logic [RUN_W-1:0] run_length;

  modport source (output valid, output command, output bit_index, output run_length,
                  input ready);
  modport sink   (input valid, input command, input bit_index, input run_length,
                  output ready);
endinterface

// Response channel: one response per request
interface bfa_rsp_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [START_W-1:0] run_start;

  modport source (output valid, output found, output run_start, input ready);
  modport sink   (input valid, input found, input run_start, output ready);
endinterface

// Configuration write channel: covered length register
interface bfa_cfg_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bitmap_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit: first-fit clear-run allocator
// Keeps MAP_BITS allocation bits; sets, clears or searches them.
//
//   channel  | dir | flow        | payload
//   ---------+-----+-------------+-------------------------------------
//   in_req   | in  | valid/ready | command, bit_index, run_length
//   out_rsp  | out | valid/ready | found, run_start
//   cfg_wr   | in  | valid/ready | data (covered length, always ready)
//
// Set and clear fetch the word, write the word back and hand off the result.
// A search scans one 16-bit word after another, at most ceil(span/16) words;
// the word scanner is the loop.
// A search with zero length or a length above the span answers without a scan.
// After reset a clearing pass writes zero to all ceil(MAP_BITS/16) words
// before the first request is taken.
// The output register lets a new request in while a response waits.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_unit import bfa_pkg::*; #(
  parameter int MAP_BITS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  bfa_req_if.sink      in_req,
  bfa_rsp_if.source    out_rsp,
  bfa_cfg_if.sink      cfg_wr
);

  localparam int NW = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW = $clog2(MAP_BITS + 1);
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;
  localparam int EW = CW + 1;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [AW-1:0]      wcnt_r, wcnt_nxt;
  logic [AW-1:0]      last_r, last_nxt;
  logic [EW-1:0]      begin_r, begin_nxt;
  logic [EW-1:0]      want_r, want_nxt;
  logic [EW-1:0]      span_r, span_nxt;
  logic [WORD_LW-1:0] bit_sel_r, bit_sel_nxt;
  logic               set_val_r, set_val_nxt;
  logic               wr_ok_r, wr_ok_nxt;
  logic               res_found_r, res_found_nxt;
  logic [START_W-1:0] res_start_r, res_start_nxt;
  logic               out_valid_r;
  logic               out_found_r;
  logic [START_W-1:0] out_start_r;

  logic               in_acc;
  logic               out_free;
  logic [EW-1:0]      span_in;
  logic [EW-1:0]      want_in;
  logic [EW-1:0]      len_ext;
  logic [EW-1:0]      map_ext;
  logic [EW-1:0]      base;
  mem_cmd_t           mem_cmd;
  logic [AW-1:0]      mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;
  logic               scan_hit;
  logic [EW-1:0]      scan_start;
  logic [EW-1:0]      scan_begin;

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  // Covered span and wanted length at request time
  assign len_ext = EW'(len_r);
  assign map_ext = EW'(MAP_BITS);
  assign span_in = (len_ext > map_ext) ? map_ext : len_ext;
  assign want_in = EW'(in_req.run_length);
  assign base    = EW'({wcnt_r, {WORD_LW{1'b0}}});

  // Word store and word scanner
  bfa_bitmap_mem #(
    .DEPTH  (NW),
    .ADDR_W (AW)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bfa_run_scan #(
    .EW (EW)
  ) u_scan (
    .word      (mem_rdata),
    .base      (base),
    .begin_in  (begin_r),
    .want      (want_r),
    .span      (span_r),
    .hit       (scan_hit),
    .start     (scan_start),
    .begin_out (scan_begin)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (wcnt_r == AW'(NW - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.command == CMD_CLEAR || in_req.command == CMD_SET) begin
            state_nxt = ST_WRITE;
          end else if (in_req.command == CMD_SEARCH && want_in != '0 &&
                       want_in <= span_in) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (scan_hit || wcnt_r == last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    wcnt_nxt      = wcnt_r;
    last_nxt      = last_r;
    begin_nxt     = begin_r;
    want_nxt      = want_r;
    span_nxt      = span_r;
    bit_sel_nxt   = bit_sel_r;
    set_val_nxt   = set_val_r;
    wr_ok_nxt     = wr_ok_r;
    res_found_nxt = res_found_r;
    res_start_nxt = res_start_r;
    mem_cmd       = '0;
    mem_addr      = wcnt_r;
    mem_wdata     = '0;
    case (state_r)
      ST_INIT: begin
        mem_cmd.wr_en = 1'b1;
        wcnt_nxt      = wcnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          if (in_req.command == CMD_CLEAR || in_req.command == CMD_SET) begin
            mem_cmd.rd_en = 1'b1;
            mem_addr      = AW'(in_req.bit_index >> WORD_LW);
            wcnt_nxt      = AW'(in_req.bit_index >> WORD_LW);
            bit_sel_nxt   = in_req.bit_index[WORD_LW-1:0];
            set_val_nxt   = (in_req.command == CMD_SET);
            wr_ok_nxt     = EW'(in_req.bit_index) < map_ext;
          end else if (in_req.command == CMD_SEARCH) begin
            if (want_in == '0) begin
              res_found_nxt = 1'b1;
            end else if (want_in <= span_in) begin
              mem_cmd.rd_en = 1'b1;
              mem_addr      = '0;
              wcnt_nxt      = '0;
              begin_nxt     = '0;
              want_nxt      = want_in;
              span_nxt      = span_in;
              last_nxt      = AW'((span_in - EW'(1)) >> WORD_LW);
            end
          end
        end
      end
      ST_WRITE: begin
        mem_cmd.wr_en       = wr_ok_r;
        mem_wdata           = mem_rdata;
        mem_wdata[bit_sel_r] = set_val_r;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          res_found_nxt = 1'b1;
          res_start_nxt = scan_start[START_W-1:0];
        end else if (wcnt_r != last_r) begin
          // Fetch the next word while this one is evaluated
          mem_cmd.rd_en = 1'b1;
          mem_addr      = wcnt_r + AW'(1);
          wcnt_nxt      = wcnt_r + AW'(1);
          begin_nxt     = scan_begin;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and request registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    begin_r     <= begin_nxt;
    want_r      <= want_nxt;
    span_r      <= span_nxt;
    bit_sel_r   <= bit_sel_nxt;
    set_val_r   <= set_val_nxt;
    wr_ok_r     <= wr_ok_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
  end

  // Covered length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RST;
    end else if (cfg_wr.valid) begin
      len_r <= cfg_wr.data;
    end
  end

  // Output register: load from the done state, drop on handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_found_r <= res_found_r;
      out_start_r <= res_start_r;
    end
  end

  assign in_req.ready      = (state_r == ST_IDLE);
  assign cfg_wr.ready      = 1'b1;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.found     = out_found_r;
  assign out_rsp.run_start = out_start_r;

`ifndef SYNTHESIS
  // Word counter never runs past the last covered word
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> wcnt_r <= last_r)
    else $error("scan word counter passed the last covered word");

  // A zero-length search answers found at once
  a_zero_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req.command == CMD_SEARCH && in_req.run_length == '0
    |=> state_r == ST_DONE && res_found_r && res_start_r == '0)
    else $error("zero-length search did not report found at start zero");

  // A word write always follows a request taken in idle
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> $past(state_r) == ST_IDLE && $past(in_acc))
    else $error("word write without a set or clear request");
`endif

endmodule

// File: rtl/core/bfa_bitmap_mem.sv
// ----------------------------------------------------------------------------
// bfa_bitmap_mem: allocation bit store
// Single-address word memory with registered read data.
// ----------------------------------------------------------------------------
module bfa_bitmap_mem import bfa_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  mem_cmd_t          cmd,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Write a word or fetch a word
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bfa_run_scan.sv
// ----------------------------------------------------------------------------
// bfa_run_scan: one-word clear-run evaluator
// Finds the first bit of a word that completes a run of clear bits, carrying
// the start of the open run from the previous word.
// ----------------------------------------------------------------------------
module bfa_run_scan import bfa_pkg::*; #(
  parameter int EW = 12
) (
  input  logic [WORD_W-1:0] word,
  input  logic [EW-1:0]     base,
  input  logic [EW-1:0]     begin_in,
  input  logic [EW-1:0]     want,
  input  logic [EW-1:0]     span,
  output logic              hit,
  output logic [EW-1:0]     start,
  output logic [EW-1:0]     begin_out
);

  logic [EW-1:0]     lane_begin [WORD_W];
  logic [EW-1:0]     lane_pos   [WORD_W];
  logic [WORD_W-1:0] cond;

  // Per-bit lanes: start of the clear run ending here, and run completion
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      lane_begin[j] = begin_in;
      for (int k = 0; k <= j; k++) begin
        if (word[k]) begin
          lane_begin[j] = base + EW'(k + 1);
        end
      end
      lane_pos[j] = base + EW'(j);
      cond[j] = !word[j] && (lane_pos[j] < span) &&
                (lane_pos[j] + EW'(1) >= lane_begin[j] + want);
    end
  end

  // Pick the lowest completing lane; its run start is the first-fit start
  always_comb begin
    start = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cond[j]) begin
        start = lane_begin[j];
      end
    end
  end

  assign hit       = |cond;
  assign begin_out = lane_begin[WORD_W-1];

endmodule
